FILE: rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types, constants and helpers for the RGB min-max contrast stretch.
// ----------------------------------------------------------------------------
package lcs_pkg;

	localparam int MAX_PIXELS = 65536;
	localparam int ADDR_W     = $clog2(MAX_PIXELS);
	localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
	localparam int SAMPLE_W   = 8;
	localparam int NUM_CH     = 3;
	localparam int DIV_STEPS  = 4;   // two quotient bits per step
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef logic [SAMPLE_W-1:0]              sample_t;
	typedef logic [NUM_CH-1:0][SAMPLE_W-1:0]  pixel_t;   // [2] red, [1] green, [0] blue
	typedef logic [CNT_W-1:0]                 count_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // store one pixel, update min/max
		logic rd_issue;  // read transaction taken: check for data, start store read
		logic setup;     // load divider lanes from the read data
		logic div_step;  // two restoring division steps per lane
		logic push;      // move the result into the output register
	} lcs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic rd_empty;  // no pixel left to read
	} lcs_status_t;

	// One restoring division step: returns {quotient bit, new remainder}.
	// The remainder stays below den, so the partial remainder fits nine bits.
	function automatic logic [SAMPLE_W:0] div_bit(input sample_t rem, input logic nb,
			input sample_t den);
		logic [SAMPLE_W:0] t;
		logic [SAMPLE_W:0] d;
		t = {rem, nb};
		d = {1'b0, den};
		if (t >= d) begin
			t = t - d;
			div_bit = {1'b1, t[SAMPLE_W-1:0]};
		end else begin
			div_bit = {1'b0, t[SAMPLE_W-1:0]};
		end
	endfunction

endpackage

FILE: rtl/lcs_req_if.sv
// ----------------------------------------------------------------------------
// lcs_req_if
// Request channel: load or read function with one RGB pixel.
// ----------------------------------------------------------------------------
interface lcs_req_if;
	import lcs_pkg::*;

	logic    valid;
	logic    ready;
	logic    func;
	sample_t red_sample;
	sample_t green_sample;
	sample_t blue_sample;

	modport source (output valid, func, red_sample, green_sample, blue_sample, input ready);
	modport sink   (input valid, func, red_sample, green_sample, blue_sample, output ready);

endinterface

FILE: rtl/lcs_rsp_if.sv
// ----------------------------------------------------------------------------
// lcs_rsp_if
// Response channel: one display pixel with frame flags.
// ----------------------------------------------------------------------------
interface lcs_rsp_if;
	import lcs_pkg::*;

	logic    valid;
	logic    ready;
	sample_t red_out;
	sample_t green_out;
	sample_t blue_out;
	logic    last_pixel;
	logic    empty_read;

	modport source (output valid, red_out, green_out, blue_out, last_pixel, empty_read,
		input ready);
	modport sink   (input valid, red_out, green_out, blue_out, last_pixel, empty_read,
		output ready);

endinterface

FILE: rtl/linear_contrast_stretch_rgb_unit.sv
// ----------------------------------------------------------------------------
// linear_contrast_stretch_rgb_unit
// Min-max linear contrast stretch for a frame of RGB pixels.
// ----------------------------------------------------------------------------
// A load transaction (func = 0) writes one pixel into a 65536-entry frame
// store and updates the running min and max of each channel; it returns
// nothing. A read transaction (func = 1) returns the next stored pixel in
// load order, stretched to 255*(x-min)/(max-min) per channel when
// stretch_mode is 1, or unchanged when it is 0. A flat channel gives 0, and
// a read with nothing left returns empty_read = 1 with zero colors. The
// first load after reading starts a new frame; loads into a full store are
// dropped. A read passes the frame store's registered read port, divider
// setup, four steps of the three radix-4 restoring divider lanes and the
// move into the output register; an empty read goes straight to that move.
// The output register lets a new transaction be taken while a result still
// waits on rsp. stretch_mode is written through cfg_we / cfg_wdata while the
// block is idle: a rule for the user that the block itself does not enforce.
// ----------------------------------------------------------------------------
module linear_contrast_stretch_rgb_unit (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	lcs_req_if.sink   req,
	lcs_rsp_if.source rsp
);
	import lcs_pkg::*;

	lcs_cmd_t    cmd;
	lcs_status_t status;
	pixel_t      load_pixel;
	pixel_t      out_pixel;

	// red in the top byte, blue in the bottom byte
	assign load_pixel = {req.red_sample, req.green_sample, req.blue_sample};

	// sequencer: decides which datapath step runs each cycle
	lcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// store, statistics, divider lanes and output payload
	lcs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.load_pixel (load_pixel),
		.cmd        (cmd),
		.status     (status),
		.out_pixel  (out_pixel),
		.out_last   (rsp.last_pixel),
		.out_empty  (rsp.empty_read)
	);

	assign rsp.red_out   = out_pixel[2];
	assign rsp.green_out = out_pixel[1];
	assign rsp.blue_out  = out_pixel[0];

endmodule

FILE: rtl/lcs_ctrl.sv
// ----------------------------------------------------------------------------
// lcs_ctrl
// Sequencer for load and read transactions and the output register valid.
// ----------------------------------------------------------------------------
module lcs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_func,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  lcs_pkg::lcs_status_t status,
	output lcs_pkg::lcs_cmd_t    cmd
);
	import lcs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MEM  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_PUSH = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              rsp_valid_q;
	logic              req_take;
	logic              slot_free;

	assign req_ready = (state_q == ST_IDLE);
	assign req_take  = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					if (req_func == FUNC_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.rd_issue = 1'b1;
						state_d = status.rd_empty ? ST_PUSH : ST_MEM;
					end
				end
			end
			ST_MEM: begin
				cmd.setup = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (slot_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.setup) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/lcs_dp.sv
// ----------------------------------------------------------------------------
// lcs_dp
// Frame store, per-channel min/max, read pointer, three divider lanes and
// the output payload register.
// ----------------------------------------------------------------------------
module lcs_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  lcs_pkg::pixel_t      load_pixel,
	input  lcs_pkg::lcs_cmd_t    cmd,
	output lcs_pkg::lcs_status_t status,
	output lcs_pkg::pixel_t      out_pixel,
	output logic                 out_last,
	output logic                 out_empty
);
	import lcs_pkg::*;

	// frame store, one write and one registered read port
	pixel_t       mem [MAX_PIXELS];
	pixel_t       rd_data_q;

	logic         mode_q;
	logic         reading_q;
	count_t       count_q;
	count_t       rd_idx_q;
	sample_t      min_q [NUM_CH];
	sample_t      max_q [NUM_CH];
	logic         empty_q;
	logic         last_q;

	// divider lanes
	sample_t      rem_q [NUM_CH];
	sample_t      num_q [NUM_CH];
	sample_t      den_q [NUM_CH];
	sample_t      quo_q [NUM_CH];
	logic         byp_q [NUM_CH];
	sample_t      bypv_q [NUM_CH];

	pixel_t       out_q;
	logic         out_last_q;
	logic         out_empty_q;

	count_t       eff_cnt;
	logic         first_px;
	logic         full;

	// a load after reading opens a new frame
	assign eff_cnt  = reading_q ? '0 : count_q;
	assign first_px = (eff_cnt == '0);
	assign full     = (eff_cnt == CNT_W'(MAX_PIXELS));

	assign status.rd_empty = (rd_idx_q >= count_q);

	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			mem[eff_cnt[ADDR_W-1:0]] <= load_pixel;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem[rd_idx_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			reading_q <= 1'b0;
			count_q   <= '0;
			rd_idx_q  <= '0;
			for (int c = 0; c < NUM_CH; c++) begin
				min_q[c] <= '0;
				max_q[c] <= '0;
			end
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (cmd.load) begin
				if (reading_q) begin
					reading_q <= 1'b0;
					rd_idx_q  <= '0;
				end
				if (!full) begin
					count_q <= eff_cnt + 1'b1;
					for (int c = 0; c < NUM_CH; c++) begin
						if (first_px || load_pixel[c] < min_q[c]) begin
							min_q[c] <= load_pixel[c];
						end
						if (first_px || load_pixel[c] > max_q[c]) begin
							max_q[c] <= load_pixel[c];
						end
					end
				end
			end
			if (cmd.rd_issue) begin
				reading_q <= 1'b1;
				if (!status.rd_empty) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
		end
	end

	// read flags, divider lanes and output payload
	always_ff @(posedge clk) begin
		logic [2*SAMPLE_W-1:0] dvd;
		logic [SAMPLE_W:0]     b1;
		logic [SAMPLE_W:0]     b0;
		sample_t               diff;
		if (cmd.rd_issue) begin
			empty_q <= status.rd_empty;
			last_q  <= (rd_idx_q + 1'b1 == count_q);
		end
		for (int c = 0; c < NUM_CH; c++) begin
			// 255*d = (d << 8) - d; quotient stays below 256
			diff = rd_data_q[c] - min_q[c];
			dvd  = {diff, {SAMPLE_W{1'b0}}} - {{SAMPLE_W{1'b0}}, diff};
			b1   = div_bit(rem_q[c], num_q[c][SAMPLE_W-1], den_q[c]);
			b0   = div_bit(b1[SAMPLE_W-1:0], num_q[c][SAMPLE_W-2], den_q[c]);
			if (cmd.setup) begin
				rem_q[c]  <= dvd[2*SAMPLE_W-1:SAMPLE_W];
				num_q[c]  <= dvd[SAMPLE_W-1:0];
				den_q[c]  <= max_q[c] - min_q[c];
				byp_q[c]  <= !mode_q || (max_q[c] <= min_q[c]) || (rd_data_q[c] < min_q[c]);
				bypv_q[c] <= mode_q ? '0 : rd_data_q[c];
			end else if (cmd.div_step) begin
				rem_q[c] <= b0[SAMPLE_W-1:0];
				num_q[c] <= {num_q[c][SAMPLE_W-3:0], 2'b00};
				quo_q[c] <= {quo_q[c][SAMPLE_W-3:0], b1[SAMPLE_W], b0[SAMPLE_W]};
			end
			if (cmd.push) begin
				out_q[c] <= empty_q ? '0 : (byp_q[c] ? bypv_q[c] : quo_q[c]);
			end
		end
		if (cmd.push) begin
			out_last_q  <= !empty_q && last_q;
			out_empty_q <= empty_q;
		end
	end

	assign out_pixel = out_q;
	assign out_last  = out_last_q;
	assign out_empty = out_empty_q;

endmodule
